>>> rtl/core/dmap_pkg.sv
package dmap_pkg;

	localparam int SPEED_W = 16;
	localparam int CFG_W   = 15;
	localparam int DUTY_W  = 7;
	localparam int NUM_W   = 22;
	localparam int DIV_W   = 18;
	localparam int QUO_W   = 8;
	localparam int STEP_W  = 3;

	localparam logic [CFG_W-1:0] DEAD_ZONE_RST = 15'd3277;
	localparam logic [CFG_W-1:0] DOMAIN_RST    = 15'd13763;

	// Q1.15 value of 0.5 and the fixed-point form of the motor law
	localparam logic signed [16:0] HALF_Q15   = 17'sd16384;
	localparam logic signed [23:0] POS_OFFSET = 24'sd2949120;
	localparam logic signed [23:0] NEG_OFFSET = 24'sd3276800;
	localparam logic signed [23:0] POS_GAIN   = 24'sd12;
	localparam logic signed [23:0] NEG_GAIN   = 24'sd11;

	localparam logic [QUO_W-1:0]  DUTY_MAX_Q = 8'd100;
	localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;

	localparam logic REG_DEAD_ZONE = 1'b0;
	localparam logic REG_DOMAIN    = 1'b1;

	typedef enum logic [1:0] {
		KIND_ZERO = 2'd0,
		KIND_FULL = 2'd1,
		KIND_DIV  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic              fwd;
		logic [NUM_W-1:0]  num;
		logic [DIV_W-1:0]  div;
	} side_job_t;

	typedef struct packed {
		side_job_t right;
		side_job_t left;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/core/dmap_front.sv
module dmap_front (
	input  logic signed [dmap_pkg::SPEED_W-1:0] speed,
	input  logic [dmap_pkg::CFG_W-1:0]          dead_zone,
	input  logic [dmap_pkg::CFG_W-1:0]          domain,
	output dmap_pkg::side_job_t                 job
);
	import dmap_pkg::*;

	logic signed [16:0] rs;
	logic [16:0]        mag;
	logic               pos;
	logic               out_band;
	logic signed [16:0] den;
	logic [14:0]        den_mag;
	logic signed [23:0] den_x;
	logic signed [23:0] num_full;
	logic [18:0]        div_full;

	assign rs       = {speed[SPEED_W-1], speed};
	assign mag      = speed[SPEED_W-1] ? 17'(-rs) : 17'(rs);
	assign pos      = !speed[SPEED_W-1] && (speed != '0);
	assign out_band = (mag < {2'b00, dead_zone}) || (mag > {2'b00, domain});

	assign den     = pos ? (rs - HALF_Q15) : (rs + HALF_Q15);
	assign den_mag = den[16] ? 15'(-den) : 15'(den);
	assign den_x   = {{7{den[16]}}, den};

	// numerator is always negative here, so take its magnitude directly
	assign num_full = pos ? (POS_OFFSET - POS_GAIN * den_x) : (NEG_OFFSET - NEG_GAIN * den_x);
	assign div_full = {den_mag, 4'b0000} - {4'b0000, den_mag};

	always_comb begin
		job.num = num_full[NUM_W-1:0];
		job.div = div_full[DIV_W-1:0];
		if (out_band) begin
			job.kind = KIND_ZERO;
			job.fwd  = 1'b1;
		end else if (den == '0) begin
			job.kind = KIND_FULL;
			job.fwd  = pos;
		end else begin
			job.kind = KIND_DIV;
			job.fwd  = den[16];
		end
	end

endmodule

>>> rtl/core/dmap_queue.sv
module dmap_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  dmap_pkg::job_t  wr_data,
	input  logic            rd_en,
	output dmap_pkg::job_t  rd_data,
	output dmap_pkg::q_status_t status
);
	import dmap_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign rd_data      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/dmap_back.sv
module dmap_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_avail,
	input  dmap_pkg::job_t              job,
	output logic                        job_take,
	input  logic                        slot_free,
	output logic                        result_load,
	output logic [dmap_pkg::DUTY_W-1:0] right_duty,
	output logic [dmap_pkg::DUTY_W-1:0] left_duty,
	output logic                        right_forward,
	output logic                        left_forward,
	output logic                        right_reversal,
	output logic                        left_reversal
);
	import dmap_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t             state_q;
	job_t               job_q;
	logic               side_q;
	logic [STEP_W-1:0]  step_q;
	logic [NUM_W-1:0]   rem_q;
	logic [DIV_W-1:0]   dv_q;
	logic [QUO_W-1:0]   quo_q;
	logic [DUTY_W-1:0]  duty_r_q;
	logic [DUTY_W-1:0]  duty_l_q;
	logic               last_r_q;
	logic               last_l_q;

	side_job_t          cur;
	logic [24:0]        shifted;
	logic               ge;
	logic [QUO_W-1:0]   quo_next;
	logic [DUTY_W-1:0]  side_duty;

	assign cur      = side_q ? job_q.left : job_q.right;
	assign shifted  = {7'd0, dv_q} << step_q;
	assign ge       = {3'd0, rem_q} >= shifted;
	assign quo_next = {quo_q[QUO_W-2:0], ge};

	always_comb begin
		case (cur.kind)
			KIND_ZERO: side_duty = '0;
			KIND_FULL: side_duty = DUTY_MAX;
			default:   side_duty = (quo_next > DUTY_MAX_Q) ? DUTY_MAX : quo_next[DUTY_W-1:0];
		endcase
	end

	assign job_take    = (state_q == ST_IDLE) && job_avail;
	assign result_load = (state_q == ST_DONE) && slot_free;

	assign right_duty     = duty_r_q;
	assign left_duty      = duty_l_q;
	assign right_forward  = job_q.right.fwd;
	assign left_forward   = job_q.left.fwd;
	assign right_reversal = job_q.right.fwd != last_r_q;
	assign left_reversal  = job_q.left.fwd != last_l_q;

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q <= job;
			rem_q <= job.right.num;
			dv_q  <= job.right.div;
			quo_q <= '0;
		end else if (state_q == ST_RUN) begin
			if (step_q == '0) begin
				rem_q <= job_q.left.num;
				dv_q  <= job_q.left.div;
				quo_q <= '0;
				if (side_q) begin
					duty_l_q <= side_duty;
				end else begin
					duty_r_q <= side_duty;
				end
			end else begin
				if (ge) begin
					rem_q <= rem_q - shifted[NUM_W-1:0];
				end
				quo_q <= quo_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			side_q   <= 1'b0;
			step_q   <= '0;
			last_r_q <= 1'b1;
			last_l_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_avail) begin
						state_q <= ST_RUN;
						side_q  <= 1'b0;
						step_q  <= '1;
					end
				end
				ST_RUN: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						side_q <= 1'b1;
						if (side_q) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						last_r_q <= job_q.right.fwd;
						last_l_q <= job_q.left.fwd;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/differential_drive_pwm_mapper.sv
// Differential drive PWM mapper. Each request carries a signed Q1.15 speed
// pair (right, left); each result gives, per side, a duty cycle in percent
// (0..100, truncated), a direction line (1 = forward) and a reversal flag
// that is set when the direction differs from the previous request's, which
// tells the motor driver to stop the PWM before switching the direction line.
// Speeds whose magnitude lies below dead_zone_low or above domain_high map to
// zero duty, forward. A request is classified on entry and parked in a
// two-deep job queue; the back end then runs one shared restoring divider,
// 8 steps per side, taking each request through a load state, the right then
// the left divide steps and a hand-off that waits for a free result slot.
// Up to two requests can wait in the job queue and one finished result in
// the output slot, so push stays open while a result waits to be popped until
// the queue fills. Registers: dead_zone_low at byte 0x0, domain_high at 0x4,
// 15 bits each; the user writes them only while the block is idle (unenforced).
module differential_drive_pwm_mapper (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	// request side
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [dmap_pkg::SPEED_W-1:0]  right_speed,
	input  logic signed [dmap_pkg::SPEED_W-1:0]  left_speed,
	// result side
	output logic                                 empty,
	input  logic                                 pop,
	output logic [dmap_pkg::DUTY_W-1:0]          right_duty,
	output logic [dmap_pkg::DUTY_W-1:0]          left_duty,
	output logic                                 right_forward,
	output logic                                 left_forward,
	output logic                                 right_reversal,
	output logic                                 left_reversal
);
	import dmap_pkg::*;

	logic [CFG_W-1:0]  dead_zone_q;
	logic [CFG_W-1:0]  domain_q;
	logic              cfg_wr;

	job_t              new_job;
	job_t              head_job;
	q_status_t         q_stat;
	logic              req_accept;
	logic              job_take;

	logic              out_valid_q;
	logic              slot_free;
	logic              result_load;

	logic [DUTY_W-1:0] b_right_duty;
	logic [DUTY_W-1:0] b_left_duty;
	logic              b_right_fwd;
	logic              b_left_fwd;
	logic              b_right_rev;
	logic              b_left_rev;

	// ---- configuration registers ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= DEAD_ZONE_RST;
			domain_q    <= DOMAIN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DEAD_ZONE: dead_zone_q <= pwdata[CFG_W-1:0];
				REG_DOMAIN:    domain_q    <= pwdata[CFG_W-1:0];
				default:       dead_zone_q <= dead_zone_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEAD_ZONE: prdata = {17'd0, dead_zone_q};
			REG_DOMAIN:    prdata = {17'd0, domain_q};
			default:       prdata = '0;
		endcase
	end

	// ---- front: classify both sides on entry ----
	dmap_front u_front_right (
		.speed     (right_speed),
		.dead_zone (dead_zone_q),
		.domain    (domain_q),
		.job       (new_job.right)
	);

	dmap_front u_front_left (
		.speed     (left_speed),
		.dead_zone (dead_zone_q),
		.domain    (domain_q),
		.job       (new_job.left)
	);

	assign full       = q_stat.full;
	assign req_accept = push && !q_stat.full;

	// ---- job queue between front and back ----
	dmap_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (req_accept),
		.wr_data (new_job),
		.rd_en   (job_take),
		.rd_data (head_job),
		.status  (q_stat)
	);

	// ---- back: shared divider and direction tracking ----
	assign slot_free = !out_valid_q || pop;

	dmap_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_avail      (!q_stat.empty),
		.job            (head_job),
		.job_take       (job_take),
		.slot_free      (slot_free),
		.result_load    (result_load),
		.right_duty     (b_right_duty),
		.left_duty      (b_left_duty),
		.right_forward  (b_right_fwd),
		.left_forward   (b_left_fwd),
		.right_reversal (b_right_rev),
		.left_reversal  (b_left_rev)
	);

	// ---- output slot ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			right_duty     <= b_right_duty;
			left_duty      <= b_left_duty;
			right_forward  <= b_right_fwd;
			left_forward   <= b_left_fwd;
			right_reversal <= b_right_rev;
			left_reversal  <= b_left_rev;
		end
	end

	assign empty = !out_valid_q;

	// ---- checks ----
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (right_duty <= DUTY_MAX) && (left_duty <= DUTY_MAX))
		else $error("duty above full scale");

	// inside the band the quotient never drops below 11, so zero duty means stopped
	a_zero_duty_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (right_duty != '0 || right_forward) && (left_duty != '0 || left_forward))
		else $error("stopped side reported in reverse");

	a_rev_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(result_load && !b_right_rev) |=> (right_forward == $past(u_back.last_r_q)))
		else $error("reversal flag inconsistent with stored direction");

	a_take_only_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> !q_stat.empty)
		else $error("back end took a job from an empty queue");

endmodule

>>> bench/differential_drive_pwm_mapper_tb.sv
`timescale 1ns / 100ps

module differential_drive_pwm_mapper_tb;

	import dmap_pkg::*;

	// Per-side motor law in raw Q1.15 counts
	localparam longint HALF_RAW   = 16384;
	localparam longint POS_BIAS   = 2949120;
	localparam longint NEG_BIAS   = 3276800;
	localparam longint POS_SLOPE  = 12;
	localparam longint NEG_SLOPE  = 11;
	localparam longint DUTY_DIV   = 15;
	localparam longint DUTY_LIMIT = 100;

	// Slack for the divider to go quiet after the last result
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [DUTY_W-1:0] right_duty;
		logic [DUTY_W-1:0] left_duty;
		logic              right_forward;
		logic              left_forward;
		logic              right_reversal;
		logic              left_reversal;
	} drive_cmd_t;

	// Tracks the band limits and last directions, predicts each result
	class drive_scoreboard;
		logic [CFG_W-1:0] dead_zone;
		logic [CFG_W-1:0] domain;
		logic             last_right_fwd;
		logic             last_left_fwd;
		drive_cmd_t       pending_cmds[$];
		int               faults;

		function new();
			dead_zone      = DEAD_ZONE_RST;
			domain         = DOMAIN_RST;
			last_right_fwd = 1'b1;
			last_left_fwd  = 1'b1;
			faults         = 0;
		endfunction

		function void set_reg(logic sel, logic [CFG_W-1:0] value);
			if (sel == REG_DEAD_ZONE)
				dead_zone = value;
			else
				domain = value;
		endfunction

		function void flag(string what, longint exp_val, longint act_val);
			faults++;
			if (faults <= MAX_REPORTS)
				$display("%0t mismatch %s: expected %0d, got %0d", $realtime, what,
					exp_val, act_val);
		endfunction

		function void map_track(logic signed [SPEED_W-1:0] speed, output logic fwd,
				output logic [DUTY_W-1:0] duty);
			longint r, mag, num, den, q;
			r   = speed;
			mag = (r < 0) ? -r : r;
			// outside the band: stopped, forward
			if (mag < dead_zone || mag > domain) begin
				fwd  = 1'b1;
				duty = '0;
				return;
			end
			// zero speed goes through the reverse branch
			if (r > 0) begin
				den = r - HALF_RAW;
				num = POS_SLOPE * den - POS_BIAS;
			end else begin
				den = r + HALF_RAW;
				num = NEG_SLOPE * den - NEG_BIAS;
			end
			// pole at +/-0.5: full duty, direction from the sign of the speed
			if (den == 0) begin
				fwd  = (r > 0);
				duty = DUTY_W'(DUTY_LIMIT);
				return;
			end
			fwd = (num == 0) || ((num > 0) == (den > 0));
			if (num < 0)
				num = -num;
			if (den < 0)
				den = -den;
			q    = num / (DUTY_DIV * den);
			duty = (q > DUTY_LIMIT) ? DUTY_W'(DUTY_LIMIT) : DUTY_W'(q);
		endfunction

		function void note_request(logic signed [SPEED_W-1:0] rs,
				logic signed [SPEED_W-1:0] ls);
			drive_cmd_t c;
			map_track(rs, c.right_forward, c.right_duty);
			map_track(ls, c.left_forward, c.left_duty);
			c.right_reversal = (c.right_forward != last_right_fwd);
			c.left_reversal  = (c.left_forward != last_left_fwd);
			last_right_fwd   = c.right_forward;
			last_left_fwd    = c.left_forward;
			pending_cmds.push_back(c);
		endfunction

		function void check_result(drive_cmd_t act);
			drive_cmd_t e;
			if (pending_cmds.size() == 0) begin
				flag("unexpected result, right_duty", -1, act.right_duty);
				return;
			end
			e = pending_cmds.pop_front();
			if (act.right_duty != e.right_duty)
				flag("right_duty", e.right_duty, act.right_duty);
			if (act.left_duty != e.left_duty)
				flag("left_duty", e.left_duty, act.left_duty);
			if (act.right_forward != e.right_forward)
				flag("right_forward", e.right_forward, act.right_forward);
			if (act.left_forward != e.left_forward)
				flag("left_forward", e.left_forward, act.left_forward);
			if (act.right_reversal != e.right_reversal)
				flag("right_reversal", e.right_reversal, act.right_reversal);
			if (act.left_reversal != e.left_reversal)
				flag("left_reversal", e.left_reversal, act.left_reversal);
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [2:0]                 paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       push;
	logic                       full;
	logic signed [SPEED_W-1:0]  right_speed;
	logic signed [SPEED_W-1:0]  left_speed;
	logic                       empty;
	logic                       pop;
	logic [DUTY_W-1:0]          right_duty;
	logic [DUTY_W-1:0]          left_duty;
	logic                       right_forward;
	logic                       left_forward;
	logic                       right_reversal;
	logic                       left_reversal;

	drive_scoreboard sb;

	differential_drive_pwm_mapper dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.push           (push),
		.full           (full),
		.right_speed    (right_speed),
		.left_speed     (left_speed),
		.empty          (empty),
		.pop            (pop),
		.right_duty     (right_duty),
		.left_duty      (left_duty),
		.right_forward  (right_forward),
		.left_forward   (left_forward),
		.right_reversal (right_reversal),
		.left_reversal  (left_reversal)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("differential_drive_pwm_mapper_tb: FAIL");
		$finish;
	end

	// Receiver: switches between free-running, coin-flip and long-stall modes
	// at random intervals so stalls land on every phase of the divider.
	int pop_mode;
	int pop_mode_left;
	int pop_hold;

	always @(posedge clk) begin
		if (pop_mode_left == 0) begin
			pop_mode      = $urandom_range(0, 2);
			pop_mode_left = $urandom_range(50, 300);
		end
		pop_mode_left--;
		if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else begin
			case (pop_mode)
				0: begin
					pop <= 1'b1;
				end
				1: begin
					pop <= 1'($urandom_range(0, 1));
				end
				default: begin
					if ($urandom_range(0, 5) == 0)
						pop_hold = $urandom_range(1, 20);
					pop <= (pop_hold == 0);
				end
			endcase
		end
	end

	// Result monitor: a result moves on an edge with pop high and empty low
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result('{right_duty, left_duty, right_forward, left_forward,
				right_reversal, left_reversal});
	end

	// Speed picker: mostly inside the current band, some at its edges, some near
	// the poles at +/-0.5, the rest anywhere in the 16-bit range.
	function automatic logic signed [SPEED_W-1:0] pick_speed(int lo, int hi);
		int mag;
		int tmp;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				mag = $urandom_range(lo, hi);
			end
			6: begin
				tmp = $urandom_range(0, 1) ? lo : hi;
				mag = tmp + $urandom_range(0, 2) - 1;
			end
			7: begin
				mag = HALF_RAW + $urandom_range(0, 64) - 32;
			end
			default: begin
				return SPEED_W'($urandom());
			end
		endcase
		if (mag < 0)
			mag = 0;
		if (mag > 32767)
			mag = 32767;
		return SPEED_W'($urandom_range(0, 1) ? -mag : mag);
	endfunction

	// One request: hold push until an edge sees full low
	task automatic send(logic signed [SPEED_W-1:0] rs, logic signed [SPEED_W-1:0] ls);
		push        <= 1'b1;
		right_speed <= rs;
		left_speed  <= ls;
		do
			@(posedge clk);
		while (full);
		sb.note_request(rs, ls);
	endtask

	// APB write: setup, then access until pready
	task automatic write_reg(logic sel, logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		// junk above bit 14 must be dropped by the block
		pwdata  <= {17'($urandom_range(0, 131071)), value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(sel, value);
	endtask

	task automatic read_reg(logic sel);
		logic [31:0] want;
		want    = (sel == REG_DEAD_ZONE) ? sb.dead_zone : sb.domain;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== want)
			sb.flag("register readback", want, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(int dz, int dh);
		write_reg(REG_DEAD_ZONE, CFG_W'(dz));
		write_reg(REG_DOMAIN, CFG_W'(dh));
		read_reg(REG_DEAD_ZONE);
		read_reg(REG_DOMAIN);
	endtask

	// Wait for every expected result, then let the divider go quiet
	task automatic drain();
		push <= 1'b0;
		while (sb.pending_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Field extremes, poles, band edges; pairing the list against its own
	// reverse mixes directions and so flips the reversal flags.
	task automatic run_directed();
		int vals[$];
		int dz;
		int dh;
		dz   = sb.dead_zone;
		dh   = sb.domain;
		vals = '{0, 1, -1, 32767, -32768, 16384, -16384, 16383, -16383, 16385,
			-16385, dz, -dz, dz - 1, 1 - dz, dh, -dh, dh + 1, -dh - 1, 3277, -13763};
		foreach (vals[i])
			send(SPEED_W'(vals[i]), SPEED_W'(vals[vals.size() - 1 - i]));
	endtask

	// Sender bursts with random gaps; about a quarter of bursts run back to back
	task automatic run_random(int count);
		int sent;
		int burst;
		int gap;
		int lo;
		int hi;
		sent = 0;
		lo   = sb.dead_zone;
		hi   = sb.domain;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < count; i++) begin
				send(pick_speed(lo, hi), pick_speed(lo, hi));
				sent++;
			end
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		int dz;
		sb          = new();
		clk         = 1'b0;
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		push        <= 1'b0;
		pop         <= 1'b0;
		right_speed <= '0;
		left_speed  <= '0;
		pop_mode      = 0;
		pop_mode_left = 0;
		pop_hold      = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset band
		read_reg(REG_DEAD_ZONE);
		read_reg(REG_DOMAIN);
		run_directed();
		run_random(260);

		// widest band: zero speed and both poles are inside
		drain();
		configure(0, 32767);
		run_directed();
		run_random(300);

		// empty band: everything stops
		drain();
		configure(32767, 0);
		run_random(60);

		// only zero speed inside
		drain();
		configure(0, 0);
		run_random(60);

		// band is the poles alone
		drain();
		configure(16384, 16384);
		run_random(60);

		repeat (5) begin
			drain();
			dz = $urandom_range(0, 20000);
			configure(dz, $urandom_range(dz, 32767));
			run_random(240);
		end

		drain();
		if (sb.faults == 0)
			$display("differential_drive_pwm_mapper_tb: PASS");
		else
			$display("differential_drive_pwm_mapper_tb: FAIL");
		$finish;
	end

endmodule
